[src/lsh_pkg.sv]
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpening unit
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic MODE_NEG_CENTRE = 1'b0;
    localparam logic MODE_POS_CENTRE = 1'b1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;

    typedef struct packed {
        logic [PIX_W-1:0] sample;
        logic [COL_W-1:0] addr;
        logic             emit;
        logic             border;
        logic             last;
    } t_s1_item;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] enhanced_value;
        logic [PIX_W-1:0] edge_value;
    } t_result;

endpackage

[src/laplacian_sharpen_3x3_unit.sv]
// result timing: a result is queued from the second stage after the request completing
// its window, which arrives one line plus one pixel after the pixel itself
// throughput: one request per cycle bar queue stalls, set by the line memory's single RMW
// reset: registers back to defaults (mode 0, 640 x 480, position 0); the line memory is
// not cleared, every entry is rewritten in a frame before any result depends on it
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_unit
// Four-neighbour Laplacian edge and sharpened output over a raster stream,
// two line buffers in one memory, 3x3 window and a small output queue
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // sample
    input  logic                                s_axis_tuser,   // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // edge_value, enhanced_value
    output logic                                m_axis_tlast    // frame_last
);

    localparam int PW = lsh_pkg::PIX_W;
    localparam int CW = lsh_pkg::COL_W;
    localparam int RW = lsh_pkg::ROW_W;
    localparam int DW = lsh_pkg::DIM_W;

    // configuration
    logic          r_kernel_mode;
    logic [DW-1:0] r_image_width;
    logic [DW-1:0] r_image_height;
    logic [DW-1:0] width_c;
    logic [DW-1:0] height_c;

    // position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // acceptance stage
    logic          at_flush;
    logic          ignore_req;
    logic          take;
    logic          col_pos;
    logic [RW-1:0] cen_row;
    logic [CW-1:0] cen_col;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          col_wrap;
    lsh_pkg::t_s1_item s0_item;

    // line memory {upper, middle}
    logic [2*PW-1:0] r_mem [lsh_pkg::MAX_WIDTH];
    logic [2*PW-1:0] r_rd;
    logic            r_fwd_valid;
    logic [2*PW-1:0] r_fwd_data;
    logic [2*PW-1:0] rd_data;
    logic [2*PW-1:0] wr_data;

    // second stage
    logic              r_s1_valid;
    lsh_pkg::t_s1_item r_s1;
    logic [PW-1:0]     r_w2, r_w4, r_w5, r_w8;
    logic [PW-1:0]     top_px, mid_px;
    logic [PW+1:0]     nsum;
    logic [PW+1:0]     ctr4;
    logic [PW+2:0]     resp;
    logic [PW-1:0]     resp_clamped;
    logic [PW-1:0]     edge_px;
    logic [PW-1:0]     enh_px;
    logic              push;
    lsh_pkg::t_result  res;

    // output queue
    lsh_pkg::t_result r_fifo [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;
    logic             pop;

    // clamped frame size
    always_comb begin
        if (r_image_width == '0) begin
            width_c = DW'(1);
        end else if (r_image_width > DW'(lsh_pkg::MAX_WIDTH)) begin
            width_c = DW'(lsh_pkg::MAX_WIDTH);
        end else begin
            width_c = r_image_width;
        end
        if (r_image_height == '0) begin
            height_c = DW'(1);
        end else if (r_image_height > DW'(lsh_pkg::MAX_HEIGHT)) begin
            height_c = DW'(lsh_pkg::MAX_HEIGHT);
        end else begin
            height_c = r_image_height;
        end
    end

    assign s_axis_tready = (r_count + {2'b00, r_s1_valid}) <= 3'd2;

    always_comb begin
        at_flush   = DW'(r_row) >= height_c;
        ignore_req = (s_axis_tuser == lsh_pkg::KIND_FLUSH) && !at_flush;
        take       = s_axis_tvalid && s_axis_tready && !ignore_req;
        col_pos    = r_col != '0;
        last_col   = CW'(width_c - DW'(1));
        last_row   = RW'(height_c - DW'(1));
        cen_row    = col_pos ? (r_row - RW'(1)) : (r_row - RW'(2));
        cen_col    = col_pos ? (r_col - CW'(1)) : last_col;
        col_wrap   = (DW'(r_col) + DW'(1)) >= width_c;

        s0_item.sample = at_flush ? '0 : s_axis_tdata;
        s0_item.addr   = r_col;
        s0_item.emit   = (r_row >= RW'(2)) || ((r_row == RW'(1)) && col_pos);
        s0_item.border = (cen_row == '0) || (cen_row == last_row) ||
                         (cen_col == '0) || (cen_col == last_col);
        s0_item.last   = (cen_row == last_row) && (cen_col == last_col);

        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we && ((i_cfg_index == lsh_pkg::REG_IMAGE_WIDTH) ||
                         (i_cfg_index == lsh_pkg::REG_IMAGE_HEIGHT))) begin
            n_col = '0;
            n_row = '0;
        end else if (take) begin
            if (s0_item.emit && s0_item.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode  <= lsh_pkg::MODE_NEG_CENTRE;
            r_image_width  <= lsh_pkg::RESET_WIDTH;
            r_image_height <= lsh_pkg::RESET_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_fwd_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lsh_pkg::REG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_data[0];
                    lsh_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    lsh_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1_valid  <= take;
            r_fwd_valid <= take && r_s1_valid && (s0_item.addr == r_s1.addr);
        end
    end

    // line memory read-modify-write
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd <= r_mem[s0_item.addr];
            r_s1 <= s0_item;
        end
        if (r_s1_valid) begin
            r_mem[r_s1.addr] <= wr_data;
        end
        r_fwd_data <= wr_data;
    end

    always_comb begin
        rd_data = r_fwd_valid ? r_fwd_data : r_rd;
        top_px  = rd_data[2*PW-1:PW];
        mid_px  = rd_data[PW-1:0];
        wr_data = {mid_px, r_s1.sample};
    end

    // window columns: r_w4 centre of the left column, r_w2/r_w5/r_w8 middle column
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_w4 <= r_w5;
            r_w2 <= top_px;
            r_w5 <= mid_px;
            r_w8 <= r_s1.sample;
        end
    end

    always_comb begin
        nsum = {2'b00, r_w2} + {2'b00, r_w8} + {2'b00, r_w4} + {2'b00, mid_px};
        ctr4 = {r_w5, 2'b00};
        if (r_kernel_mode == lsh_pkg::MODE_NEG_CENTRE) begin
            resp = {1'b0, nsum} - {1'b0, ctr4};
        end else begin
            resp = {1'b0, ctr4} - {1'b0, nsum};
        end
        if (resp[PW+2]) begin
            resp_clamped = '0;
        end else if (resp[PW+1:PW] != 2'b00) begin
            resp_clamped = '1;
        end else begin
            resp_clamped = resp[PW-1:0];
        end
        edge_px = r_s1.border ? '0 : resp_clamped;
        enh_px  = (r_w5 > edge_px) ? (r_w5 - edge_px) : '0;

        res.last           = r_s1.last;
        res.enhanced_value = enh_px;
        res.edge_value     = edge_px;
        push               = r_s1_valid && r_s1.emit;
    end

    // output queue
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = {r_fifo[r_rd_ptr].enhanced_value, r_fifo[r_rd_ptr].edge_value};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the 3x3 Laplacian sharpening unit: frames of random
// size and content go through the slave port with random idling, a built-in
// line-buffer predictor works out edge and enhanced values for each completed window,
// and the master port is checked in order against the predicted results
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PW  = lsh_pkg::PIX_W;
    localparam int DW  = lsh_pkg::DIM_W;
    localparam int IW  = lsh_pkg::CFG_IDX_W;
    localparam int CDW = lsh_pkg::CFG_DATA_W;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 900;
    localparam int          CALM_ITEMS    = 750;
    localparam logic [IW-1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic          kind;
        logic [PW-1:0] sample;
    } t_pixel_request;

    typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} t_texture;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [IW-1:0]         i_cfg_index   = '0;
    logic [CDW-1:0]        i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // sample
    logic                  s_axis_tuser  = lsh_pkg::KIND_PIXEL;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;   // edge_value, enhanced_value
    logic                  m_axis_tlast;   // frame_last

    laplacian_sharpen_3x3_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [PW-1:0]    upper_row [0:lsh_pkg::MAX_WIDTH-1];
    logic [PW-1:0]    middle_row [0:lsh_pkg::MAX_WIDTH-1];
    logic [PW-1:0]    win_pix [0:8];
    int unsigned      col_pos     = 0;
    int unsigned      row_pos     = 0;
    logic             kernel_mode = lsh_pkg::MODE_NEG_CENTRE;
    logic [DW-1:0]    width_reg   = lsh_pkg::RESET_WIDTH;
    logic [DW-1:0]    height_reg  = lsh_pkg::RESET_HEIGHT;

    lsh_pkg::t_result expected_results [$];
    t_pixel_request   pending_requests [$];

    int  requests_queued   = 0;
    int  requests_accepted = 0;
    int  results_checked   = 0;
    int  frames_done       = 0;
    int  failures          = 0;
    int  cfg_writes        = 0;
    int  counted_items     = 0;
    int  holds_asked       = 0;
    int  holds_taken       = 0;
    int  hold_left         = 0;
    int  stall_left        = 0;
    int  send_gap          = 0;
    int  cycle_count       = 0;
    bit  idling_on         = 1'b1;
    logic ready_next;
    t_pixel_request   next_req;
    lsh_pkg::t_result exp_res;

    function automatic int unsigned clamp_dimension(logic [DW-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    // one accepted request through the line buffers and window
    task automatic predict_sharpen(input logic kind, input logic [PW-1:0] sample_in);
        int unsigned      w, h, c, r, cr, cc;
        logic [PW-1:0]    samp, top, mid, ctr, edge_val, enh_val;
        int               nsum, s;
        logic             emit, is_last;
        lsh_pkg::t_result res;
        w = clamp_dimension(width_reg, lsh_pkg::MAX_WIDTH);
        h = clamp_dimension(height_reg, lsh_pkg::MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        samp = sample_in;
        if (c >= w) c = w - 1;
        // early flush is dropped without any effect
        if (kind == lsh_pkg::KIND_FLUSH && r < h) return;
        if (r >= h) samp = '0;
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = samp;
        for (int rr = 0; rr < 3; rr++) begin
            win_pix[rr*3]   = win_pix[rr*3+1];
            win_pix[rr*3+1] = win_pix[rr*3+2];
        end
        win_pix[2] = top;
        win_pix[5] = mid;
        win_pix[8] = samp;
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c >= 1) begin
            cr = r - 1;
            cc = c - 1;
        end else begin
            cr = r - 2;
            cc = w - 1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (!emit) return;
        ctr = win_pix[4];
        edge_val = '0;
        if (cr != 0 && cr != h - 1 && cc != 0 && cc != w - 1) begin
            nsum = int'(win_pix[1]) + int'(win_pix[7]) + int'(win_pix[3]) + int'(win_pix[5]);
            if (kernel_mode == lsh_pkg::MODE_NEG_CENTRE) s = nsum - 4 * int'(ctr);
            else s = 4 * int'(ctr) - nsum;
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            edge_val = s[7:0];
        end
        enh_val = (ctr > edge_val) ? ctr - edge_val : '0;
        is_last = (cr == h - 1) && (cc == w - 1);
        res.edge_value = edge_val;
        res.enhanced_value = enh_val;
        res.last = is_last;
        expected_results.push_back(res);
        if (is_last) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sharpen(s_axis_tuser, s_axis_tdata);
                requests_accepted++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // holding the offered request
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idling_on && pending_requests.size() != 0
                         && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 12);
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                next_req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_req.sample;
                s_axis_tuser  <= next_req.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_checked++;
                if (m_axis_tlast) frames_done++;
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: edge %0d enhanced %0d last %0d",
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.edge_value !== m_axis_tdata[7:0]
                        || exp_res.enhanced_value !== m_axis_tdata[15:8]
                        || exp_res.last !== m_axis_tlast) begin
                        failures++;
                        if (failures <= 10)
                            $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                     results_checked, exp_res.edge_value,
                                     exp_res.enhanced_value, exp_res.last,
                                     m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (holds_taken != holds_asked) begin
                holds_taken++;
                hold_left = HOLD_CYCLES - 1;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    task automatic write_register(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            lsh_pkg::REG_KERNEL_MODE: kernel_mode = value[0];
            lsh_pkg::REG_IMAGE_WIDTH: begin
                width_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            lsh_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic kind, input logic [PW-1:0] sample);
        t_pixel_request req;
        req.kind = kind;
        req.sample = sample;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_row3(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        queue_request(lsh_pkg::KIND_PIXEL, a);
        queue_request(lsh_pkg::KIND_PIXEL, b);
        queue_request(lsh_pkg::KIND_PIXEL, c);
    endtask

    function automatic logic [PW-1:0] pick_sample(t_texture texture);
        case (texture)
            TEXTURE_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            TEXTURE_FLAT:   return PW'($urandom_range(100, 140));
            default:        return PW'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(input int count, input t_texture texture, input bit noisy);
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(0, 39) == 0)
                queue_request(lsh_pkg::KIND_FLUSH, PW'($urandom_range(0, 255)));
            queue_request(lsh_pkg::KIND_PIXEL, pick_sample(texture));
            counted_items++;
        end
    endtask

    // pixels in the flush rows act as flush requests
    task automatic queue_flushes(input int count, input bit noisy);
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(0, 7) == 0)
                queue_request(lsh_pkg::KIND_PIXEL, PW'($urandom_range(0, 255)));
            else
                queue_request(lsh_pkg::KIND_FLUSH, PW'($urandom_range(0, 255)));
            counted_items++;
        end
    endtask

    task automatic drain();
        while (requests_accepted != requests_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_dimension(int top_size);
        if ($urandom_range(0, 11) == 0) return '0;
        return DW'($urandom_range(1, top_size));
    endfunction

    initial begin
        int       w, h, spin;
        bit       restart_due;
        t_texture texture;
        for (int i = 0; i < lsh_pkg::MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) win_pix[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frames: strongest response of each kernel at the single interior pixel
        write_register(lsh_pkg::REG_KERNEL_MODE, DW'(lsh_pkg::MODE_NEG_CENTRE));
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 11'd3);
        write_register(REG_UNUSED, 11'h7FF);
        queue_row3(8'd17, 8'd255, 8'd34);
        queue_row3(8'd255, 8'd0, 8'd255);
        queue_row3(8'd51, 8'd255, 8'd68);
        queue_request(lsh_pkg::KIND_FLUSH, 8'h00);
        queue_request(lsh_pkg::KIND_PIXEL, 8'hAA);
        queue_request(lsh_pkg::KIND_FLUSH, 8'hFF);
        queue_request(lsh_pkg::KIND_FLUSH, 8'h55);
        drain();
        write_register(lsh_pkg::REG_KERNEL_MODE, DW'(lsh_pkg::MODE_POS_CENTRE));
        queue_row3(8'd200, 8'd0, 8'd9);
        queue_row3(8'd0, 8'd255, 8'd0);
        queue_request(lsh_pkg::KIND_FLUSH, 8'h3C);
        queue_row3(8'd128, 8'd0, 8'd1);
        repeat (4) queue_request(lsh_pkg::KIND_FLUSH, 8'h00);
        drain();

        // tallest frame with width zero, long output hold-off
        write_register(lsh_pkg::REG_KERNEL_MODE, DW'(lsh_pkg::MODE_NEG_CENTRE));
        write_register(lsh_pkg::REG_IMAGE_WIDTH, 11'd0);
        write_register(lsh_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        queue_pixels(lsh_pkg::MAX_HEIGHT, TEXTURE_NOISE, 1'b0);
        queue_flushes(2, 1'b0);
        holds_asked++;
        drain();

        counted_items = 0;
        restart_due = 1'b1;
        while (counted_items < RANDOM_ITEMS) begin
            if (restart_due || $urandom_range(0, 2) == 0) begin
                drain();
                write_register(lsh_pkg::REG_KERNEL_MODE, DW'($urandom_range(0, 1)));
                if (restart_due || $urandom_range(0, 3) != 0)
                    write_register(lsh_pkg::REG_IMAGE_WIDTH, pick_dimension(12));
                if ($urandom_range(0, 3) != 0)
                    write_register(lsh_pkg::REG_IMAGE_HEIGHT, pick_dimension(8));
                restart_due = 1'b0;
            end
            idling_on = (counted_items < CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            w = clamp_dimension(width_reg, lsh_pkg::MAX_WIDTH);
            h = clamp_dimension(height_reg, lsh_pkg::MAX_HEIGHT);
            texture = t_texture'($urandom_range(0, 2));
            if ($urandom_range(0, 11) == 0) begin
                // frame cut short, restarted by the next size write
                queue_pixels($urandom_range(0, w * h - 1), texture, 1'b1);
                drain();
                restart_due = 1'b1;
            end else begin
                queue_pixels(w * h, texture, 1'b1);
                queue_flushes(w + 1, 1'b1);
                if (idling_on && h >= 3 && $urandom_range(0, 15) == 0) begin
                    holds_asked++;
                    drain();
                end
                if ($urandom_range(0, 5) == 0) drain();
            end
        end
        idling_on = 1'b0;

        spin = 0;
        while ((requests_accepted != requests_queued || expected_results.size() != 0)
               && spin < 50000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (requests_accepted != requests_queued) begin
            $display("%0d requests never accepted", requests_queued - requests_accepted);
            failures++;
        end
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            failures += expected_results.size();
        end
        $display("%0d requests, %0d results checked over %0d frames, %0d register writes",
                 requests_accepted, results_checked, frames_done, cfg_writes);
        $display("both kernels, small frames, a 1024-row frame, %0d long hold-offs, %0d failures",
                 holds_taken, failures);
        if (failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lsh_pkg.sv
src/laplacian_sharpen_3x3_unit.sv
test/tb_top.sv
